@@ design/q2e_pkg.sv @@
// shared types, constants and helper functions for the quaternion to euler core
package q2e_pkg;

    localparam int COMP_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int SUM_W     = 34;
    localparam int SQ_STAGES = 31;

    typedef struct packed {
        logic signed [COMP_W-1:0] q_x;
        logic signed [COMP_W-1:0] q_y;
        logic signed [COMP_W-1:0] q_z;
        logic signed [COMP_W-1:0] q_w;
    } t_q2e_in;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_about_x;
        logic signed [ANGLE_W-1:0] angle_about_y;
        logic signed [ANGLE_W-1:0] angle_about_z;
        logic                      y_clamped;
    } t_q2e_out;

    // values carried alongside the square root pipeline
    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [30:0]      sp;
        logic                    clamp;
        logic                    neg;
    } t_q2e_side;

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_q2e_flag;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i), full turn = 2^32
    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round half up to the output angle width
    function automatic logic [ANGLE_W-1:0] quant(input logic [31:0] a);
        logic [31:0] s;
        s = a + (32'd1 << (32 - ANGLE_W - 1));
        return s[31 -: ANGLE_W];
    endfunction

endpackage

@@ design/q2e_isqrt.sv @@
// pipelined floor square root, one result bit per stage
module q2e_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_n,
    output logic [30:0] o_root
);
    import q2e_pkg::*;

    logic [61:0] r_rem  [0:SQ_STAGES];
    logic [30:0] r_root [0:SQ_STAGES];

    assign r_rem[0]  = i_n;
    assign r_root[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SQ_STAGES; g++) begin : g_stage
            localparam int K = SQ_STAGES - 1 - g;
            logic [61:0] t;
            logic [61:0] n_rem;
            logic [30:0] n_root;
            logic [61:0] r_rem_q;
            logic [30:0] r_root_q;
            always_comb begin
                t = (62'(r_root[g]) << (K + 1)) + (62'd1 << (2 * K));
                if (r_rem[g] >= t) begin
                    n_rem  = r_rem[g] - t;
                    n_root = r_root[g] | (31'd1 << K);
                end else begin
                    n_rem  = r_rem[g];
                    n_root = r_root[g];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_q  <= n_rem;
                    r_root_q <= n_root;
                end
            end
            assign r_rem[g+1]  = r_rem_q;
            assign r_root[g+1] = r_root_q;
        end
    endgenerate

    assign o_root = r_root[SQ_STAGES];

endmodule

@@ design/q2e_cordic.sv @@
// pipelined vectoring cordic giving atan2(y, x) as a 32-bit binary angle
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [q2e_pkg::SUM_W-1:0] i_y,
    input  logic signed [q2e_pkg::SUM_W-1:0] i_x,
    output logic [31:0]                     o_angle
);
    import q2e_pkg::*;

    localparam int W = SUM_W + 3;

    logic signed [W-1:0] r_x [0:STAGES];
    logic signed [W-1:0] r_y [0:STAGES];
    logic [31:0]         r_z [0:STAGES];
    logic                r_zero [0:STAGES];

    logic signed [W-1:0] n_x, n_y;
    logic [31:0]         n_z;

    // quadrant fold so that x is not negative
    always_comb begin
        n_x = W'(i_x);
        n_y = W'(i_y);
        n_z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x = W'(i_y);
                n_y = -W'(i_x);
                n_z = QUARTER_TURN;
            end else begin
                n_x = -W'(i_y);
                n_y = W'(i_x);
                n_z = 32'd0 - QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            logic signed [W-1:0] dx, dy;
            assign dx = r_y[g] >>> g;
            assign dy = r_x[g] >>> g;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[g+1] <= r_zero[g];
                    if (r_y[g] > 0) begin
                        r_x[g+1] <= r_x[g] + dx;
                        r_y[g+1] <= r_y[g] - dy;
                        r_z[g+1] <= r_z[g] + atan_val(g);
                    end else begin
                        r_x[g+1] <= r_x[g] - dx;
                        r_y[g+1] <= r_y[g] + dy;
                        r_z[g+1] <= r_z[g] - atan_val(g);
                    end
                end
            end
        end
    endgenerate

    assign o_angle = r_zero[STAGES] ? 32'd0 : r_z[STAGES];

endmodule

@@ design/quaternion_to_euler_core.sv @@
// top level: quaternion to z-y-x euler angles, fully pipelined
//
// Converts a Q1.15 quaternion (x, y, z, w) into three 16-bit binary angles
// (32768 = pi) about x, y and z, plus a flag when the y angle is clamped to
// +-pi/2. One beat is accepted every clock while the output is not stalled.
// The pipe holds a multiply stage, a sum stage, a square stage, a remainder
// stage, a 31-stage bit-per-stage square root for the asin cosine term, then
// three parallel cordic pipelines and an output register. The whole pipe
// advances together whenever the output register is empty or being taken, so
// a stalled result holds every stage in place.
module quaternion_to_euler_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  q2e_pkg::t_q2e_in  i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output q2e_pkg::t_q2e_out o_item
);
    import q2e_pkg::*;

    localparam int CL = CORDIC_STAGES + 1;
    localparam int NV = 4 + SQ_STAGES + CL;
    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);

    logic en;
    logic r_vld [0:NV-1];
    logic r_out_valid;
    t_q2e_out r_out;

    // global advance: output slot free or being drained
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // stage 1: exact Q1.15 products (equal to the floored Q.30 products)
    logic signed [31:0] r_p_wx, r_p_yz, r_p_xx, r_p_yy, r_p_wy;
    logic signed [31:0] r_p_zx, r_p_wz, r_p_xy, r_p_zz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_wx <= i_item.q_w * i_item.q_x;
            r_p_yz <= i_item.q_y * i_item.q_z;
            r_p_xx <= i_item.q_x * i_item.q_x;
            r_p_yy <= i_item.q_y * i_item.q_y;
            r_p_wy <= i_item.q_w * i_item.q_y;
            r_p_zx <= i_item.q_z * i_item.q_x;
            r_p_wz <= i_item.q_w * i_item.q_z;
            r_p_xy <= i_item.q_x * i_item.q_y;
            r_p_zz <= i_item.q_z * i_item.q_z;
        end
    end

    // stage 2: sine and cosine terms
    logic signed [SUM_W-1:0] r_sr, r_cr, r_sp, r_sy, r_cy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= (SUM_W'(r_p_wx) + SUM_W'(r_p_yz)) <<< 1;
            r_cr <= ONE_Q30 - ((SUM_W'(r_p_xx) + SUM_W'(r_p_yy)) <<< 1);
            r_sp <= (SUM_W'(r_p_wy) - SUM_W'(r_p_zx)) <<< 1;
            r_sy <= (SUM_W'(r_p_wz) + SUM_W'(r_p_xy)) <<< 1;
            r_cy <= ONE_Q30 - ((SUM_W'(r_p_yy) + SUM_W'(r_p_zz)) <<< 1);
        end
    end

    // stage 3: clamp test and square of the sine term
    logic        sp_hi, sp_lo;
    logic signed [30:0] sp_nar;
    logic [59:0] r_sp2;
    t_q2e_side   r_side3, r_side4;
    assign sp_hi  = r_sp >= ONE_Q30;
    assign sp_lo  = r_sp <= -ONE_Q30;
    assign sp_nar = r_sp[30:0];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp2         <= 60'(sp_nar * sp_nar);
            r_side3.sr    <= r_sr;
            r_side3.cr    <= r_cr;
            r_side3.sy    <= r_sy;
            r_side3.cy    <= r_cy;
            r_side3.sp    <= sp_nar;
            r_side3.clamp <= sp_hi || sp_lo;
            r_side3.neg   <= sp_lo;
        end
    end

    // stage 4: remainder 1 - s^2 in Q.60
    logic [61:0] r_rem;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem   <= (62'd1 << 60) - 62'(r_sp2);
            r_side4 <= r_side3;
        end
    end

    // square root pipeline with the other terms riding alongside
    logic [30:0] root;
    q2e_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (r_rem),
        .o_root (root)
    );

    t_q2e_side r_sdl [0:SQ_STAGES-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdl[0] <= r_side4;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_sdl[k] <= r_sdl[k-1];
            end
        end
    end

    t_q2e_side side_q;
    assign side_q = r_sdl[SQ_STAGES-1];

    // three cordic pipelines in parallel
    logic [31:0] ang_x, ang_y, ang_z;
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (side_q.sr),
        .i_x     (side_q.cr),
        .o_angle (ang_x)
    );
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (SUM_W'(side_q.sp)),
        .i_x     (SUM_W'({1'b0, root})),
        .o_angle (ang_y)
    );
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (side_q.sy),
        .i_x     (side_q.cy),
        .o_angle (ang_z)
    );

    // clamp flags follow the cordic latency
    t_q2e_flag r_fdl [0:CL-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fdl[0].clamp <= side_q.clamp;
            r_fdl[0].neg   <= side_q.neg;
            for (int k = 1; k < CL; k++) begin
                r_fdl[k] <= r_fdl[k-1];
            end
        end
    end

    logic [31:0] ang_y_sel;
    always_comb begin
        if (r_fdl[CL-1].clamp) begin
            ang_y_sel = r_fdl[CL-1].neg ? (32'd0 - QUARTER_TURN) : QUARTER_TURN;
        end else begin
            ang_y_sel = ang_y;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[NV-1];
        end
    end

    // output register with rounding to the angle width
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.angle_about_x <= quant(ang_x);
            r_out.angle_about_y <= quant(ang_y_sel);
            r_out.angle_about_z <= quant(ang_z);
            r_out.y_clamped     <= r_fdl[CL-1].clamp;
        end
    end

endmodule

@@ dv/tb.sv @@
// testbench for the quaternion to euler core: random and directed quaternions checked against a model
`timescale 1ns / 100ps

module tb;
    import q2e_pkg::*;

    localparam int STAGES   = 16;
    localparam int LATENCY  = 4 + 31 + STAGES + 1 + 1;
    localparam int N_RANDOM = 1850;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_q2e_in  i_item = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_q2e_out o_item;

    bit long_hold = 1'b0;
    bit inputs_done = 1'b0;

    always #4 i_clk = ~i_clk;

    quaternion_to_euler_core #(.CORDIC_STAGES(STAGES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    // floor shift of a signed value
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return floor_shift(a * b, 30);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring cordic, full turn = 2^32
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint t;
        longint dx;
        longint dy;
        acc = 32'd0;
        if (x == 0 && y == 0) return 32'd0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                acc = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                acc = 32'd0 - QUARTER_TURN;
            end
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                acc += atan_val(i);
            end else begin
                x -= dx;
                y += dy;
                acc -= atan_val(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [ANGLE_W-1:0] round_angle(logic [31:0] a);
        logic [31:0] s;
        s = a + (32'd1 << (32 - ANGLE_W - 1));
        return s[31 -: ANGLE_W];
    endfunction

    function automatic t_q2e_out euler_angles(t_q2e_in q);
        t_q2e_out r;
        longint x, y, z, w, sr, cr, sp, sy, cy;
        longint one;
        logic [31:0] ay;
        one = 64'sd1 << 30;
        x = longint'(q.q_x) <<< 15;
        y = longint'(q.q_y) <<< 15;
        z = longint'(q.q_z) <<< 15;
        w = longint'(q.q_w) <<< 15;
        sr = 2 * (mul_q30(w, x) + mul_q30(y, z));
        cr = one - 2 * (mul_q30(x, x) + mul_q30(y, y));
        sp = 2 * (mul_q30(w, y) - mul_q30(z, x));
        sy = 2 * (mul_q30(w, z) + mul_q30(x, y));
        cy = one - 2 * (mul_q30(y, y) + mul_q30(z, z));
        r.y_clamped = 1'b0;
        if (sp >= one) begin
            ay = QUARTER_TURN;
            r.y_clamped = 1'b1;
        end else if (sp <= -one) begin
            ay = 32'd0 - QUARTER_TURN;
            r.y_clamped = 1'b1;
        end else begin
            ay = vector_angle(sp, int_sqrt(longint'((64'd1 << 60) - sp * sp)));
        end
        r.angle_about_x = round_angle(vector_angle(sr, cr));
        r.angle_about_y = round_angle(ay);
        r.angle_about_z = round_angle(vector_angle(sy, cy));
        return r;
    endfunction

    class angle_board;
        t_q2e_out pending[$];
        int errors = 0;

        function void note_quaternion(t_q2e_in q);
            pending.push_back(euler_angles(q));
        endfunction

        function void check_angles(t_q2e_out got);
            t_q2e_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.angle_about_x !== exp_r.angle_about_x) begin
                $display("%0t angle_about_x exp %0d got %0d", $time,
                         exp_r.angle_about_x, got.angle_about_x);
                errors++;
            end
            if (got.angle_about_y !== exp_r.angle_about_y) begin
                $display("%0t angle_about_y exp %0d got %0d", $time,
                         exp_r.angle_about_y, got.angle_about_y);
                errors++;
            end
            if (got.angle_about_z !== exp_r.angle_about_z) begin
                $display("%0t angle_about_z exp %0d got %0d", $time,
                         exp_r.angle_about_z, got.angle_about_z);
                errors++;
            end
            if (got.y_clamped !== exp_r.y_clamped) begin
                $display("%0t y_clamped exp %0d got %0d", $time,
                         exp_r.y_clamped, got.y_clamped);
                errors++;
            end
        endfunction
    endclass

    angle_board board = new();

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_quaternion(i_item);
            if (o_valid && i_ready) board.check_angles(o_item);
        end
    end

    // receiver stall pattern, with one long hold-off while the sender keeps offering beats
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (long_hold) i_ready <= 1'b0;
            else if (cyc % 300 < 60) i_ready <= 1'b1;
            else if (cyc % 300 < 180) i_ready <= ($urandom_range(0, 3) != 0);
            else i_ready <= ($urandom_range(0, 1) != 0);
        end
    end

    initial begin
        repeat (150) @(negedge i_clk);
        long_hold = 1'b1;
        repeat (200) @(negedge i_clk);
        long_hold = 1'b0;
    end

    // offer one beat and hold it until accepted
    task automatic send_quaternion(t_q2e_in q);
        i_valid <= 1'b1;
        i_item <= q;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_q2e_in unit_like();
        t_q2e_in q;
        int big;
        big = $urandom_range(0, 3);
        q.q_x = 16'($urandom_range(0, 23170) * ($urandom_range(0, 1) ? 1 : -1));
        q.q_y = 16'($urandom_range(0, 23170) * ($urandom_range(0, 1) ? 1 : -1));
        q.q_z = 16'($urandom_range(0, 23170) * ($urandom_range(0, 1) ? 1 : -1));
        q.q_w = 16'($urandom_range(0, 23170) * ($urandom_range(0, 1) ? 1 : -1));
        if (big == 0) q.q_w = 16'sh7fff;
        return q;
    endfunction

    initial begin
        t_q2e_in q;
        int burst;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity, extremes, near gimbal lock both ways, a clamped pitch, zero vector, half turn
        send_quaternion('{16'sd0, 16'sd0, 16'sd0, 16'sh7fff});
        send_quaternion('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_quaternion('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_quaternion('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_quaternion('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170});
        send_quaternion('{16'sd0, -16'sd23170, 16'sd0, 16'sd23170});
        send_quaternion('{16'sd0, 16'sd23171, 16'sd0, 16'sd23171});
        send_quaternion('{16'sd0, 16'sd16384, 16'sd0, 16'sd16384});
        send_quaternion('{16'sd0, 16'sd16384, 16'sd0, -16'sd16384});
        send_quaternion('{16'sh7fff, 16'sd0, 16'sd0, 16'sd0});
        send_quaternion('{16'sd0, 16'sd0, 16'sh7fff, 16'sd0});
        send_quaternion('{16'sd0, 16'sh7fff, 16'sd0, 16'sd0});
        send_quaternion('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
        send_quaternion('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170});
        send_quaternion('{16'sd0, 16'sd0, 16'sd23170, -16'sd23170});
        send_quaternion('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
        send_quaternion('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
        send_quaternion('{16'sd1, -16'sd1, 16'sd1, -16'sd1});

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                if ($urandom_range(0, 3) == 0) q = t_q2e_in'({$urandom, $urandom});
                else q = unit_like();
                send_quaternion(q);
            end
            if ($urandom_range(0, 2) != 0) send_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;
        inputs_done = 1'b1;
    end

    initial begin
        wait (inputs_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
